[rtl/core/ps2_scan_code_decoder_core_macros.svh]
// Assertion macros shared by the scan code decoder RTL.
`ifndef PS2_SCAN_CODE_DECODER_CORE_MACROS_SVH
`define PS2_SCAN_CODE_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PS2D_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PS2D_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/ps2d_pkg.sv]
// Types, prefix codes and the set 1 to set 2 table of the scan code decoder.
package ps2d_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] code_t;

	// Sequence state of the prefix decoder.
	typedef struct packed {
		logic       waiting;
		logic [1:0] remaining;
		logic       released;
		logic       extended;
		code_t      code;
	} seq_t;

	localparam byte_t PREFIX_RELEASE = 8'hF0;
	localparam byte_t PREFIX_EXT1    = 8'hE0;
	localparam byte_t PREFIX_EXT2    = 8'hE1;
	localparam byte_t BYTE_NONE      = 8'h00;
	localparam code_t PAUSE_CODE     = 16'h1477;
	localparam code_t PAUSE_FOLD     = 16'h0077;
	localparam code_t EXT_OFFSET     = 16'h0080;

	localparam seq_t SEQ_CLEAR = '{waiting: 1'b0, remaining: 2'd1, released: 1'b0,
		extended: 1'b0, code: 16'h0000};

	// Set 1 make code (low seven bits) to set 2 make code.
	localparam byte_t SET1_TO_SET2 [128] = '{
		8'h00, 8'h76, 8'h16, 8'h1e, 8'h26, 8'h25, 8'h2e, 8'h36,
		8'h3d, 8'h3e, 8'h46, 8'h45, 8'h4e, 8'h55, 8'h66, 8'h0d,
		8'h15, 8'h1d, 8'h24, 8'h2d, 8'h2c, 8'h35, 8'h3c, 8'h43,
		8'h44, 8'h4d, 8'h54, 8'h5b, 8'h5a, 8'h14, 8'h1c, 8'h1b,
		8'h23, 8'h2b, 8'h34, 8'h33, 8'h3b, 8'h42, 8'h4b, 8'h4c,
		8'h52, 8'h0e, 8'h12, 8'h5d, 8'h1a, 8'h22, 8'h21, 8'h2a,
		8'h32, 8'h31, 8'h3a, 8'h41, 8'h49, 8'h4a, 8'h59, 8'h7c,
		8'h11, 8'h29, 8'h58, 8'h05, 8'h06, 8'h04, 8'h0c, 8'h03,
		8'h0b, 8'h02, 8'h0a, 8'h01, 8'h09, 8'h77, 8'h7e, 8'h6c,
		8'h75, 8'h7d, 8'h7b, 8'h6b, 8'h73, 8'h74, 8'h79, 8'h69,
		8'h72, 8'h7a, 8'h70, 8'h71, 8'h7f, 8'h60, 8'h61, 8'h78,
		8'h07, 8'h0f, 8'h17, 8'h1f, 8'h27, 8'h2f, 8'h37, 8'h3f,
		8'h47, 8'h4f, 8'h56, 8'h5e, 8'h08, 8'h10, 8'h18, 8'h20,
		8'h28, 8'h30, 8'h38, 8'h40, 8'h48, 8'h50, 8'h57, 8'h6f,
		8'h13, 8'h19, 8'h39, 8'h51, 8'h53, 8'h5c, 8'h5f, 8'h62,
		8'h63, 8'h64, 8'h65, 8'h67, 8'h68, 8'h6a, 8'h6d, 8'h6e
	};

endpackage

[rtl/core/ps2d_cfg_if.sv]
// Configuration write channel carrying the translated mode bit.
interface ps2d_cfg_if;
	logic valid;
	logic ready;
	logic translated_mode;

	modport source (output valid, output translated_mode, input ready);
	modport sink (input valid, input translated_mode, output ready);
endinterface

[rtl/core/ps2d_byte_if.sv]
// Input channel carrying one raw keyboard byte per item.
interface ps2d_byte_if;
	import ps2d_pkg::*;

	logic  valid;
	logic  ready;
	byte_t scan_byte;

	modport source (output valid, output scan_byte, input ready);
	modport sink (input valid, input scan_byte, output ready);
endinterface

[rtl/core/ps2d_key_if.sv]
// Output channel carrying one decoded key event per item.
interface ps2d_key_if;
	import ps2d_pkg::*;

	logic  valid;
	logic  ready;
	code_t key_code;
	logic  key_released;

	modport source (output valid, output key_code, output key_released, input ready);
	modport sink (input valid, input key_code, input key_released, output ready);
endinterface

[rtl/core/ps2_scan_code_decoder_core.sv]
// Top level of the PS/2 scan code set 2 decoder.
`include "ps2_scan_code_decoder_core_macros.svh"

// The decoder takes one raw keyboard byte per item on the scan channel and
// produces at most one key event per item on the key channel: a 16-bit key
// code (extended codes offset by 0x80, the extended pause code 0x1477 folded
// to 0x77 first) and a release flag. Prefix bytes (0xF0, 0xE0, 0xE1) and zero
// bytes produce no event. With translated_mode set, bytes other than 0xE0 and
// 0xE1 are first mapped back from set 1 to set 2, and a set 1 break byte acts
// as an 0xF0 prefix followed by its make code. The block sustains one item per
// clock cycle while the key channel does not stall it. A byte that completes a
// sequence passes through the input register and then the result register,
// which holds its event until the sink takes it. The throughput is set by
// the single sequence state register, which is read and updated once per
// byte. The cfg channel is always ready and should only be written while no
// byte is in flight.
module ps2_scan_code_decoder_core (
	input logic          clk,
	input logic          arst_n,
	ps2d_cfg_if.sink     cfg,
	ps2d_byte_if.sink    scan,
	ps2d_key_if.source   key
);
	import ps2d_pkg::*;

	logic  mode_q;

	// Input register stage.
	logic  valid_s1;
	byte_t byte_s1;
	logic  go_s1;

	// Sequence state and its next value.
	seq_t  seq_q;
	seq_t  seq_next;

	// Result register stage.
	logic  valid_s2;
	code_t code_s2;
	logic  released_s2;

	// Combinational decode results.
	logic  pre_release;
	byte_t data_byte;
	seq_t  seq_pre;
	logic  emit;
	code_t emit_code;
	code_t folded;
	logic  emit_released;

	// The configuration register takes a write on any cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg.valid) begin
			mode_q <= cfg.translated_mode;
		end
	end

	// The input register moves on whenever the result register is free or
	// being emptied in this cycle, so a byte can enter on every cycle.
	assign go_s1      = valid_s1 && (!valid_s2 || key.ready);
	assign scan.ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.ready && scan.valid) begin
			byte_s1 <= scan.scan_byte;
		end
	end

	// Untranslation: in set 1 mode every byte except the two extended
	// prefixes goes through the table, and a break byte first injects a
	// release prefix.
	always_comb begin
		pre_release = 1'b0;
		data_byte   = byte_s1;
		if (mode_q && (byte_s1 != PREFIX_EXT1) && (byte_s1 != PREFIX_EXT2)) begin
			pre_release = byte_s1[7];
			data_byte   = SET1_TO_SET2[byte_s1[6:0]];
		end
	end

	// Prefix decoder. A zero data byte changes nothing beyond an injected release
	// prefix, which also covers a set 1 byte whose table entry is empty.
	always_comb begin
		seq_pre = seq_q;
		if (pre_release) begin
			seq_pre.released = 1'b1;
			seq_pre.waiting  = 1'b1;
		end

		seq_next      = seq_pre;
		emit          = 1'b0;
		emit_code     = seq_pre.code;
		emit_released = seq_pre.released;
		folded        = seq_pre.code;

		if (data_byte == BYTE_NONE) begin
			seq_next = seq_pre;
		end else if (data_byte == PREFIX_RELEASE) begin
			seq_next.released = 1'b1;
			seq_next.waiting  = 1'b1;
		end else if (data_byte == PREFIX_EXT1) begin
			seq_next.remaining = 2'd1;
			seq_next.extended  = 1'b1;
			seq_next.waiting   = 1'b1;
		end else if (data_byte == PREFIX_EXT2) begin
			seq_next.remaining = 2'd2;
			seq_next.extended  = 1'b1;
			seq_next.waiting   = 1'b1;
		end else begin
			// Data byte: shift it in and count down; the count wraps in
			// two bits should it ever start at zero.
			seq_next.remaining = seq_pre.remaining - 2'd1;
			seq_next.code      = {seq_pre.code[7:0], data_byte};
			if (seq_next.remaining != 2'd0) begin
				seq_next.waiting = 1'b1;
			end else begin
				folded = (seq_next.code == PAUSE_CODE) ? PAUSE_FOLD : seq_next.code;
				emit          = 1'b1;
				emit_code     = seq_pre.extended ? (folded + EXT_OFFSET) : seq_next.code;
				emit_released = seq_pre.released;
				seq_next      = SEQ_CLEAR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_CLEAR;
		end else if (go_s1) begin
			seq_q <= seq_next;
		end
	end

	// Result register: holds a finished event until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s1) begin
			valid_s2 <= emit;
		end else if (key.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			code_s2     <= emit_code;
			released_s2 <= emit_released;
		end
	end

	assign key.valid        = valid_s2;
	assign key.key_code     = code_s2;
	assign key.key_released = released_s2;

	// When no sequence is open the state must be fully cleared.
	`PS2D_ASSERT_SAME(a_idle_clear, clk, arst_n, !seq_q.waiting,
		(seq_q == SEQ_CLEAR), "idle sequence state is not cleared")

	// The byte count only ever holds one or two.
	`PS2D_ASSERT_SAME(a_remaining_range, clk, arst_n, 1'b1,
		(seq_q.remaining == 2'd1 || seq_q.remaining == 2'd2),
		"byte count left its legal range")

	// A completed sequence always shows up on the output next cycle.
	`PS2D_ASSERT_NEXT(a_emit_shown, clk, arst_n, go_s1 && emit,
		valid_s2, "completed key event was not registered")

	// A byte held in the input register is never dropped or altered.
	`PS2D_ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !go_s1,
		valid_s1 && $stable(byte_s1), "stalled input byte was lost")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the PS/2 scan code set 2 decoder core.
module tb_top;
	import ps2d_pkg::*;

	// Cycles without any handshake before the run is declared hung. The slowest
	// correct stretch is a sender gap plus a receiver stall plus the pipeline,
	// so this leaves a wide margin.
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	// Pipeline depth from byte acceptance to key event, with some slack.
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned PHASE_BYTES = 200;
	localparam int unsigned PHASE_COUNT = 6;

	typedef struct {
		code_t code;
		logic  released;
	} key_event_t;

	logic clk;
	logic arst_n;

	ps2d_cfg_if  cfg_ch ();
	ps2d_byte_if scan_ch ();
	ps2d_key_if  key_ch ();

	ps2_scan_code_decoder_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.scan   (scan_ch),
		.key    (key_ch)
	);

	// Predicted decoder state: the sequence register and the mode bit as the
	// block should hold them after every accepted item.
	seq_t        track = SEQ_CLEAR;
	logic        mode_now = 1'b0;
	key_event_t  pending_keys[$];

	bit          gaps_on = 1'b1;
	int unsigned fault_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned bytes_sent = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Every input starts at a known value; reset is asserted at time zero and
	// released once.
	initial begin
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.translated_mode <= 1'b0;
		scan_ch.valid <= 1'b0;
		scan_ch.scan_byte <= BYTE_NONE;
		key_ch.ready <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		fault_count++;
	endtask

	// Runs one set 2 byte through the prefix state machine. A data byte that
	// completes a sequence queues the key event the block must produce.
	function automatic void decode_set2(input byte_t b);
		code_t code;
		if (b == BYTE_NONE) begin
			// Zero bytes leave the sequence untouched.
		end else if (b == PREFIX_RELEASE) begin
			track.released = 1'b1;
			track.waiting = 1'b1;
		end else if (b == PREFIX_EXT1) begin
			track.remaining = 2'd1;
			track.extended = 1'b1;
			track.waiting = 1'b1;
		end else if (b == PREFIX_EXT2) begin
			track.remaining = 2'd2;
			track.extended = 1'b1;
			track.waiting = 1'b1;
		end else begin
			track.remaining = track.remaining - 2'd1;
			track.code = {track.code[7:0], b};
			if (track.remaining != 2'd0) begin
				track.waiting = 1'b1;
			end else begin
				code = track.code;
				// Extended codes move up by 0x80; the pause sequence folds first.
				if (track.extended) begin
					if (code == PAUSE_CODE)
						code = PAUSE_FOLD;
					code = code + EXT_OFFSET;
				end
				pending_keys.push_back('{code, track.released});
				track = SEQ_CLEAR;
			end
		end
	endfunction

	// In translated mode a set 1 byte is mapped back first: the extended
	// prefixes pass as they are, a break byte becomes a release prefix and
	// then its make code from the table.
	function automatic void predict_keys(input byte_t raw);
		if (mode_now && raw != PREFIX_EXT1 && raw != PREFIX_EXT2) begin
			if (raw[7])
				decode_set2(PREFIX_RELEASE);
			decode_set2(SET1_TO_SET2[raw[6:0]]);
		end else begin
			decode_set2(raw);
		end
	endfunction

	function automatic byte_t random_data_byte();
		byte_t b;
		do
			b = byte_t'($urandom_range(1, 255));
		while (b == PREFIX_RELEASE || b == PREFIX_EXT1 || b == PREFIX_EXT2);
		return b;
	endfunction

	// Sends one item, optionally after a gap. Valid stays high on return so
	// that back-to-back items need no extra assignment in the same step.
	task automatic send_byte(input byte_t b);
		int unsigned gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			scan_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		scan_ch.valid <= 1'b1;
		scan_ch.scan_byte <= b;
		do
			@(posedge clk);
		while (!scan_ch.ready);
		predict_keys(b);
		if (b != BYTE_NONE)
			bytes_sent++;
	endtask

	// Stops the byte stream and waits until every predicted key has arrived,
	// then lets prefix bytes that produce no event clear the pipeline.
	task automatic settle();
		scan_ch.valid <= 1'b0;
		while (pending_keys.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_translated(input logic m);
		cfg_ch.valid <= 1'b1;
		cfg_ch.translated_mode <= m;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		mode_now = m;
		cfg_ch.valid <= 1'b0;
	endtask

	// Set 2 mode straight out of reset, so the reset value of the mode bit is
	// exercised too. Covers plain make and break, extended codes, the pause
	// sequence, prefixes arriving inside an unfinished sequence, 16-bit wrap,
	// acknowledge bytes and zero bytes inside a sequence.
	task automatic test_set2_directed();
		send_byte(8'h1C);
		send_byte(PREFIX_RELEASE); send_byte(8'h1C);
		send_byte(PREFIX_EXT1); send_byte(PREFIX_RELEASE); send_byte(8'h75);
		send_byte(PREFIX_EXT2); send_byte(PREFIX_RELEASE); send_byte(8'h14);
		send_byte(8'h77);
		// A one-byte extended prefix after the first pause byte keeps that byte.
		send_byte(PREFIX_EXT2); send_byte(8'h14); send_byte(PREFIX_EXT1);
		send_byte(8'h70);
		send_byte(PREFIX_EXT2); send_byte(8'hFF); send_byte(8'hFF);
		send_byte(8'hFA);
		send_byte(PREFIX_EXT1); send_byte(BYTE_NONE); send_byte(8'h12);
		settle();
	endtask

	// Set 1 input: break bytes, a lone break of table entry zero that leaves
	// only the release pending, a zero byte, an extended break and the top
	// byte value.
	task automatic test_set1_directed();
		set_translated(1'b1);
		send_byte(8'h9E);
		send_byte(8'h80); send_byte(8'h1E);
		send_byte(BYTE_NONE);
		send_byte(PREFIX_EXT1); send_byte(8'hC8);
		send_byte(8'hFF);
		settle();
	endtask

	// Mostly well-formed set 2 sequences with random content, some pause
	// sequences and random noise bytes.
	task automatic send_set2_sequence();
		int unsigned pick;
		int unsigned kind;
		bit          brk;
		pick = $urandom_range(0, 99);
		kind = $urandom_range(0, 3);
		brk = $urandom_range(0, 1);
		if (pick < 15) begin
			send_byte(byte_t'($urandom_range(0, 255)));
		end else if (pick < 22) begin
			send_byte(PREFIX_EXT2);
			if (brk)
				send_byte(PREFIX_RELEASE);
			send_byte(8'h14);
			send_byte(8'h77);
		end else begin
			if (kind == 2)
				send_byte(PREFIX_EXT1);
			else if (kind == 3)
				send_byte(PREFIX_EXT2);
			if (brk)
				send_byte(PREFIX_RELEASE);
			send_byte(random_data_byte());
			if (kind == 3) begin
				// Now and then a release prefix lands between the two data bytes.
				if ($urandom_range(0, 7) == 0)
					send_byte(PREFIX_RELEASE);
				send_byte(random_data_byte());
			end
		end
	endtask

	// In set 1 almost every byte completes a key on its own; extended
	// prefixes are mixed in so that set 1 bytes also finish extended codes.
	task automatic send_set1_sequence();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			send_byte(PREFIX_EXT1);
			send_byte(byte_t'($urandom_range(0, 255)));
		end else if (pick < 22) begin
			send_byte(PREFIX_EXT2);
			send_byte(byte_t'($urandom_range(0, 255)));
			send_byte(byte_t'($urandom_range(0, 255)));
		end else begin
			send_byte(byte_t'($urandom_range(0, 255)));
		end
	endtask

	// Random phases alternate the mode. Gaps on both channels switch on and
	// off at random within a phase, and the last phase runs with none.
	task automatic test_random_phases();
		int unsigned phase;
		int unsigned start;
		bit          last;
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			last = (phase == PHASE_COUNT - 1);
			gaps_on = !last;
			set_translated(phase[0]);
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES) begin
				if ($urandom_range(0, 39) == 0)
					gaps_on = !last && $urandom_range(0, 1);
				if (mode_now)
					send_set1_sequence();
				else
					send_set2_sequence();
			end
			settle();
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		test_set2_directed();
		test_set1_directed();
		test_random_phases();
		if (fault_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Receiver side: ready drops at random while gaps are enabled, otherwise it
	// stays high.
	initial begin
		forever begin
			@(posedge clk);
			if (gaps_on && $urandom_range(0, 7) == 0) begin
				key_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			key_ch.ready <= 1'b1;
		end
	end

	// Every accepted key event is matched against the oldest prediction.
	always @(posedge clk) begin
		key_event_t want;
		if (arst_n && key_ch.valid && key_ch.ready) begin
			if (pending_keys.size() == 0) begin
				report_mismatch($sformatf("unexpected key code %h released %b",
					key_ch.key_code, key_ch.key_released));
			end else begin
				want = pending_keys.pop_front();
				if (key_ch.key_code !== want.code)
					report_mismatch($sformatf("key_code %h, predicted %h",
						key_ch.key_code, want.code));
				if (key_ch.key_released !== want.released)
					report_mismatch($sformatf("key_released %b, predicted %b for code %h",
						key_ch.key_released, want.released, want.code));
			end
		end
	end

	// Hang detection: any handshake on any channel restarts the count.
	always @(posedge clk) begin
		if ((scan_ch.valid && scan_ch.ready) || (key_ch.valid && key_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule
